[src/med5d_pkg.sv]
package med5d_pkg;

    // defaults for the top-level parameters
    localparam int SAMPLES_DEF  = 5;
    localparam int CHANNELS_DEF = 2;

    // fixed field widths
    localparam int SAMPLE_W = 12;
    localparam int DUTY_W   = 8;

    // duty scaling: (median - floor) * top / span, truncated
    localparam int DUTY_FLOOR = 10;
    localparam int ADC_TOP    = 4095;
    localparam int DUTY_TOP   = 255;
    localparam int DUTY_SPAN  = ADC_TOP - DUTY_FLOOR;
    localparam int PROD_W     = SAMPLE_W + DUTY_W;
    // division by the span as a multiply by ceil(2^32 / span) and a 32-bit shift,
    // exact over the whole product range
    localparam int RECIP_SH   = 32;
    localparam int RECIP_W    = 21;
    localparam int DUTY_RECIP = 1051400;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FEED,
        ST_MED,
        ST_SCALE,
        ST_OUT
    } t_state;

    // control shared by every sort cell
    typedef struct packed {
        logic clear;
        logic ins;
    } t_cell_ctl;

    // scaler status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_scale_stat;

endpackage

[src/med5d_cell.sv]
module med5d_cell
    import med5d_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctl           i_ctl,
    input  logic [SAMPLE_W-1:0] i_x,
    input  logic                i_left_lt,
    input  logic                i_left_vld,
    input  logic [SAMPLE_W-1:0] i_left_val,
    output logic                o_lt,
    output logic [SAMPLE_W-1:0] o_val,
    output logic                o_vld
);

    logic [SAMPLE_W-1:0] r_val;
    logic                r_vld;
    logic                w_mine;

    // an empty cell takes the new value only right behind the last filled one
    assign w_mine = r_vld ? (i_x < r_val) : i_left_vld;
    assign o_lt   = r_vld && (i_x < r_val);
    assign o_val  = r_val;
    assign o_vld  = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.clear) begin
            r_vld <= 1'b0;
        end else if (i_ctl.ins) begin
            if (i_left_lt) begin
                r_vld <= 1'b1;
            end else if (w_mine) begin
                r_vld <= 1'b1;
            end
        end
    end

    // new value lands here, or the left neighbor shifts in
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !i_ctl.clear) begin
            if (i_left_lt) begin
                r_val <= i_left_val;
            end else if (w_mine) begin
                r_val <= i_x;
            end
        end
    end

endmodule

[src/med5d_scale.sv]
module med5d_scale
    import med5d_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SAMPLE_W-1:0] i_median,
    output t_scale_stat         o_stat,
    output logic [DUTY_W-1:0]   o_duty
);

    localparam int FULL_W = PROD_W + RECIP_W;

    logic [PROD_W-1:0] r_prod;
    logic [DUTY_W-1:0] r_q;
    logic              r_busy;
    logic              r_done;
    logic [PROD_W-1:0] w_prod;
    logic [FULL_W-1:0] w_full;

    // below the floor the duty saturates at zero
    assign w_prod = (i_median < SAMPLE_W'(DUTY_FLOOR)) ? '0 :
                    PROD_W'(i_median - SAMPLE_W'(DUTY_FLOOR)) * PROD_W'(DUTY_TOP);
    // truncated quotient by the span, via the reciprocal
    assign w_full = FULL_W'(r_prod) * FULL_W'(DUTY_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    // product registered on start, quotient from the registered product while busy
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= w_prod;
        end
        if (r_busy) begin
            r_q <= w_full[RECIP_SH +: DUTY_W];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_duty      = r_q;

endmodule

[src/median_of_five_to_duty.sv]
// channel | direction | handshake        | payload
// input   | in        | i_valid/o_stall  | i_channel, i_sample
// output  | out       | o_valid/i_stall  | o_out_channel, o_median_value, o_duty
//
// a sample that does not finish its channel's block does not stall input
// the sample that finishes a block goes through the accept cycle, the block streamed
//   through the insertion-sort cell chain (one memory read per cycle), the median
//   pick and the scaler, with input stalled after the accept
// reset is synchronous and active low; it clears the fill counts, the
//   sequencer and the cell valid bits; the sample memory is not cleared
// a result held in the output register does not block input; a second finished
//   block waits for it with input stalled
module median_of_five_to_duty
    import med5d_pkg::*;
#(
    parameter int SAMPLES  = SAMPLES_DEF,
    parameter int CHANNELS = CHANNELS_DEF,
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [CH_W-1:0]     i_channel,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [CH_W-1:0]     o_out_channel,
    output logic [SAMPLE_W-1:0] o_median_value,
    output logic [DUTY_W-1:0]   o_duty
);

    localparam int DEPTH  = CHANNELS * SAMPLES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int MID    = SAMPLES / 2;

    // sequencer
    t_state r_state, n_state;
    logic [CNT_W-1:0] r_fill [CHANNELS];
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] n_idx;
    logic [CH_W-1:0]  r_chan;
    logic [SAMPLE_W-1:0] r_held;
    logic [SAMPLE_W-1:0] r_med;

    // sample memory, one block row per channel
    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;
    logic [ADDR_W-1:0]   w_wr_addr;
    logic [ADDR_W-1:0]   w_rd_addr;

    // transaction decode
    logic w_accept;
    logic w_chan_ok;
    logic w_last;
    logic [CNT_W-1:0] w_fill;

    // sort chain
    t_cell_ctl           w_ctl;
    logic [SAMPLE_W-1:0] w_x;
    logic                w_lt  [SAMPLES];
    logic [SAMPLE_W-1:0] w_val [SAMPLES];
    logic                w_vld [SAMPLES];

    // scaler and output register
    t_scale_stat       w_stat;
    logic [DUTY_W-1:0] w_duty;
    logic              w_start;
    logic              w_load;
    logic              w_out_free;
    logic              r_o_valid;
    logic [CH_W-1:0]     r_o_chan;
    logic [SAMPLE_W-1:0] r_o_med;
    logic [DUTY_W-1:0]   r_o_duty;

    assign o_stall   = (r_state != ST_IDLE);
    assign w_accept  = i_valid && !o_stall;
    // channel numbers beyond the configured count are dropped
    assign w_chan_ok = (32'(i_channel) < 32'(CHANNELS));
    assign w_fill    = w_chan_ok ? r_fill[i_channel] : '0;
    assign w_last    = (w_fill == CNT_W'(SAMPLES - 1));

    assign w_wr_addr = ADDR_W'(i_channel) * ADDR_W'(SAMPLES) + ADDR_W'(w_fill);
    assign w_rd_addr = ADDR_W'(r_chan) * ADDR_W'(SAMPLES) + ADDR_W'(r_idx);

    assign w_out_free = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (w_accept && w_chan_ok) begin
            r_mem[w_wr_addr] <= i_sample;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_fill[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (w_accept && w_chan_ok) begin
                r_fill[i_channel] <= w_last ? '0 : w_fill + 1'b1;
            end
        end
    end

    // block context for the sort pass
    always_ff @(posedge i_clk) begin
        if (w_accept && w_chan_ok && w_last) begin
            r_held <= i_sample;
            r_chan <= i_channel;
        end
        if (r_state == ST_MED) begin
            r_med <= w_val[MID];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        w_ctl     = '0;
        w_start   = 1'b0;
        w_load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_chan_ok && w_last) begin
                    w_ctl.clear = 1'b1;
                    n_idx       = '0;
                    n_state     = ST_FEED;
                end
            end
            ST_FEED: begin
                // newest sample first, then the stored ones in read order
                w_ctl.ins = 1'b1;
                n_idx     = r_idx + 1'b1;
                if (r_idx == CNT_W'(SAMPLES - 1)) begin
                    n_state = ST_MED;
                end
            end
            ST_MED: begin
                w_start = 1'b1;
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                if (w_stat.done) begin
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_x = (r_idx == '0) ? r_held : r_rd_data;

    // insertion-sort chain, ascending, empties at the high end
    for (genvar g = 0; g < SAMPLES; g++) begin : g_cell
        logic                w_left_lt;
        logic                w_left_vld;
        logic [SAMPLE_W-1:0] w_left_val;
        if (g == 0) begin : g_head
            assign w_left_lt  = 1'b0;
            assign w_left_vld = 1'b1;
            assign w_left_val = w_x;
        end else begin : g_link
            assign w_left_lt  = w_lt[g-1];
            assign w_left_vld = w_vld[g-1];
            assign w_left_val = w_val[g-1];
        end
        med5d_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_x        (w_x),
            .i_left_lt  (w_left_lt),
            .i_left_vld (w_left_vld),
            .i_left_val (w_left_val),
            .o_lt       (w_lt[g]),
            .o_val      (w_val[g]),
            .o_vld      (w_vld[g])
        );
    end

    // the chain is settled during the median cycle, so the scaler takes it directly
    med5d_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_median (w_val[MID]),
        .o_stat   (w_stat),
        .o_duty   (w_duty)
    );

    // output register, parts the result from the input side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_chan <= r_chan;
            r_o_med  <= r_med;
            r_o_duty <= w_duty;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_out_channel  = r_o_chan;
    assign o_median_value = r_o_med;
    assign o_duty         = r_o_duty;

    // every cell holds a sample when the median is taken
    a_chain_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MED) |-> w_vld[SAMPLES-1])
        else $error("sort chain not full at median pick");

    // a completing transaction starts the sort pass
    a_feed_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_chan_ok && w_last) |=> (r_state == ST_FEED))
        else $error("block completion did not start the sort pass");

    // the scaler finishes only while the sequencer waits on it
    a_done_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> (r_state == ST_SCALE))
        else $error("scaler done outside the scale state");

    // the scaler is never restarted while busy
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> !w_stat.busy)
        else $error("scaler restarted while busy");

    // a new result is loaded only after the scaler finished
    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> ((r_state == ST_SCALE) && w_stat.done) || (r_state == ST_OUT))
        else $error("output loaded without a finished result");

endmodule

[tb/median_of_five_to_duty_tb.sv]
`timescale 1ns / 100ps

module median_of_five_to_duty_tb
    import med5d_pkg::*;
();

    // run length and timeout
    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 400;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 3 * (SAMPLES_DEF + 11);

    // one completed block as seen on the output port
    typedef struct packed {
        logic                ch;
        logic [SAMPLE_W-1:0] median;
        logic [DUTY_W-1:0]   duty;
    } t_duty_result;

    // one directed row; when has_typed is set and the row closes a block,
    // the typed median and duty replace the predicted ones
    typedef struct packed {
        logic                ch;
        logic [SAMPLE_W-1:0] smp;
        logic                has_typed;
        logic [SAMPLE_W-1:0] median;
        logic [DUTY_W-1:0]   duty;
    } t_sample_row;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                i_valid   = 1'b0;
    logic                i_channel = 1'b0;
    logic [SAMPLE_W-1:0] i_sample  = '0;
    logic                i_stall   = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic                o_out_channel;
    logic [SAMPLE_W-1:0] o_median_value;
    logic [DUTY_W-1:0]   o_duty;

    // predictor state: the open block of each channel
    logic [SAMPLE_W-1:0] open_block [CHANNELS_DEF][SAMPLES_DEF];
    int unsigned         open_fill  [CHANNELS_DEF];

    t_duty_result pending_medians[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;
    int unsigned samples_sent   = 0;
    int unsigned medians_seen   = 0;
    int unsigned floor_hits     = 0;
    int unsigned top_hits       = 0;
    int unsigned cycle_count    = 0;

    // directed table: zero blocks and full-scale blocks interleaved on both
    // channels, a median just under the floor, one exactly at the floor,
    // then an unordered block with both extremes left to the predictor
    t_sample_row directed_rows [N_DIRECTED] = '{
        '{1'b0, 12'd0,    1'b0, 12'd0,    8'd0},
        '{1'b1, 12'd4095, 1'b0, 12'd0,    8'd0},
        '{1'b0, 12'd0,    1'b0, 12'd0,    8'd0},
        '{1'b1, 12'd4095, 1'b0, 12'd0,    8'd0},
        '{1'b0, 12'd0,    1'b0, 12'd0,    8'd0},
        '{1'b1, 12'd4095, 1'b0, 12'd0,    8'd0},
        '{1'b0, 12'd0,    1'b0, 12'd0,    8'd0},
        '{1'b1, 12'd4095, 1'b0, 12'd0,    8'd0},
        '{1'b0, 12'd0,    1'b1, 12'd0,    8'd0},
        '{1'b1, 12'd4095, 1'b1, 12'd4095, 8'd255},
        '{1'b0, 12'd9,    1'b0, 12'd0,    8'd0},
        '{1'b0, 12'd3000, 1'b0, 12'd0,    8'd0},
        '{1'b0, 12'd0,    1'b0, 12'd0,    8'd0},
        '{1'b0, 12'd9,    1'b0, 12'd0,    8'd0},
        '{1'b0, 12'd1,    1'b1, 12'd9,    8'd0},
        '{1'b1, 12'd10,   1'b0, 12'd0,    8'd0},
        '{1'b1, 12'd4095, 1'b0, 12'd0,    8'd0},
        '{1'b1, 12'd10,   1'b0, 12'd0,    8'd0},
        '{1'b1, 12'd2,    1'b0, 12'd0,    8'd0},
        '{1'b1, 12'd11,   1'b1, 12'd10,   8'd0},
        '{1'b0, 12'd4095, 1'b0, 12'd0,    8'd0},
        '{1'b0, 12'd0,    1'b0, 12'd0,    8'd0},
        '{1'b0, 12'd2048, 1'b0, 12'd0,    8'd0},
        '{1'b0, 12'd1,    1'b0, 12'd0,    8'd0},
        '{1'b0, 12'd4094, 1'b0, 12'd0,    8'd0}
    };

    median_of_five_to_duty dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_channel      (i_channel),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_channel  (o_out_channel),
        .o_median_value (o_median_value),
        .o_duty         (o_duty)
    );

    // 8 ns clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // timeout guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // insertion sort of a copy of the block, middle entry returned
    function automatic logic [SAMPLE_W-1:0] block_median(
        input logic [SAMPLE_W-1:0] blk [SAMPLES_DEF]
    );
        logic [SAMPLE_W-1:0] sorted [SAMPLES_DEF];
        logic [SAMPLE_W-1:0] v;
        int j;
        sorted = blk;
        for (int i = 1; i < SAMPLES_DEF; i++) begin
            v = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > v) begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = v;
        end
        return sorted[SAMPLES_DEF / 2];
    endfunction

    // (median - floor) * 255 / span, truncated; below the floor saturates to 0
    function automatic logic [DUTY_W-1:0] duty_of(input logic [SAMPLE_W-1:0] m);
        int d;
        if (m < DUTY_FLOOR) return '0;
        d = ((int'(m) - DUTY_FLOOR) * DUTY_TOP) / DUTY_SPAN;
        if (d > DUTY_TOP) d = DUTY_TOP;
        return d[DUTY_W-1:0];
    endfunction

    // update the open block on an accepted sample; queue a result when it closes
    task automatic collect_sample(input t_sample_row row);
        t_duty_result r;
        int unsigned  n;
        n = open_fill[row.ch];
        open_block[row.ch][n] = row.smp;
        n++;
        if (n < SAMPLES_DEF) begin
            open_fill[row.ch] = n;
        end else begin
            open_fill[row.ch] = 0;
            r.ch     = row.ch;
            r.median = block_median(open_block[row.ch]);
            r.duty   = duty_of(r.median);
            if (row.has_typed) begin
                r.median = row.median;
                r.duty   = row.duty;
            end
            pending_medians.push_back(r);
        end
    endtask

    // one input transaction, with random idle cycles ahead of it
    task automatic send_sample(input t_sample_row row);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_channel <= row.ch;
        i_sample  <= row.smp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        collect_sample(row);
        samples_sent++;
    endtask

    // biased toward the floor and the top of the converter range
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(3))
            0:       return SAMPLE_W'($urandom_range(20));
            1:       return SAMPLE_W'(ADC_TOP - $urandom_range(20));
            default: return SAMPLE_W'($urandom_range(ADC_TOP));
        endcase
    endfunction

    // sender holds off until every queued result has been taken
    task automatic drain_medians();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_medians.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_phase(input int unsigned count);
        t_sample_row row;
        logic        last_ch;
        last_ch = 1'b0;
        for (int unsigned k = 0; k < count; k++) begin
            // runs on one channel as well as interleaving
            row.ch        = ($urandom_range(2) == 0) ? last_ch : 1'($urandom_range(1));
            row.smp       = pick_sample();
            row.has_typed = 1'b0;
            row.median    = '0;
            row.duty      = '0;
            last_ch       = row.ch;
            send_sample(row);
        end
    endtask

    // output side: random stall and comparison against the oldest expectation
    always @(posedge i_clk) begin
        t_duty_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_medians.size() == 0) begin
                $error("unexpected result: channel %0d median %0d duty %0d",
                       o_out_channel, o_median_value, o_duty);
                error_count++;
            end else begin
                want = pending_medians.pop_front();
                medians_seen++;
                if (want.duty == 0) floor_hits++;
                if (want.duty == DUTY_TOP) top_hits++;
                if (o_out_channel !== want.ch) begin
                    $error("out_channel: expected %0d, got %0d", want.ch, o_out_channel);
                    error_count++;
                end
                if (o_median_value !== want.median) begin
                    $error("median_value: expected %0d, got %0d",
                           want.median, o_median_value);
                    error_count++;
                end
                if (o_duty !== want.duty) begin
                    $error("duty: expected %0d, got %0d", want.duty, o_duty);
                    error_count++;
                end
            end
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        for (int c = 0; c < CHANNELS_DEF; c++) begin
            open_fill[c] = 0;
            for (int s = 0; s < SAMPLES_DEF; s++) open_block[c][s] = '0;
        end

        // reset held before the first transaction
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table with mild gaps on both sides
        send_idle_pct  = 10;
        recv_stall_pct = 20;
        foreach (directed_rows[r]) send_sample(directed_rows[r]);
        drain_medians();

        // sender mostly sending, receiver mostly stalling
        send_idle_pct  = 27;
        recv_stall_pct = 64;
        random_phase(N_RANDOM / 3);
        drain_medians();

        // sender mostly idle, receiver mostly ready
        send_idle_pct  = 64;
        recv_stall_pct = 27;
        random_phase(N_RANDOM / 3);
        drain_medians();

        // back to back on both sides
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_phase(N_RANDOM - 2 * (N_RANDOM / 3));
        drain_medians();

        // let any stray result show up
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d samples on %0d channels, %0d medians checked",
                 samples_sent, CHANNELS_DEF, medians_seen);
        $display("duties at the floor: %0d, at full scale: %0d", floor_hits, top_hits);
        if (error_count == 0 && pending_medians.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
